// ----- hdl/gtpf_pkg.sv -----
// Shared types and constants for the glyph-to-page framebuffer.
// Holds the operation codes, sequencer states and the character-to-glyph map.
// No dependencies.
package gtpf_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_FONT,
        ST_LORD,
        ST_LO,
        ST_HI,
        ST_FIN
    } state_t;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] GLYPH_DIGIT_BASE = 8'd27;
    localparam int         GLYPH_COLS = 8;

    typedef logic [5:0] glyph_t;

    function automatic glyph_t glyph_of(input logic [7:0] ch);
        logic [7:0] g;
        g = 8'd0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            g = ch - CH_UPPER_A + 8'd1;
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            g = ch - CH_LOWER_A + 8'd1;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            g = ch - CH_DIGIT_0 + GLYPH_DIGIT_BASE;
        end
        return g[5:0];
    endfunction

endpackage

// ----- hdl/glyph_to_page_framebuffer.sv -----
// Top level of the glyph-to-page framebuffer: font memory, framebuffer memory
// and the sequencer that clears, loads, reads and blits glyph columns.
// Depends on gtpf_pkg.
//
//  channel | direction | words                                  | handshake
//  s_      | in        | op, pos_x, pos_y, char_code, address,  | s_valid / s_ready
//          |           | font_data                              |
//  m_      | out       | read_data, read_valid                  | m_valid / m_ready
//
// Load goes straight to the finish state, read passes ST_RD first, an off-panel
// draw goes straight to finish. A draw fetches glyph columns (ST_FONT, ST_LORD),
// writes the low page (ST_LO) and, when bits reach the next page, the high page
// (ST_HI), in turn at the single framebuffer read port. Clear writes the frame one byte a cycle.
// After reset a clearing pass over all FRAME_BYTES runs with s_ready low.
// A result waits in the output register; the next word is accepted meanwhile,
// and the sequencer holds in its finish state until the register is free.
module glyph_to_page_framebuffer #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int GLYPH_COUNT  = 37
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic signed [8:0] s_pos_x,
    input  logic signed [8:0] s_pos_y,
    input  logic [7:0]        s_char_code,
    input  logic [9:0]        s_address,
    input  logic [7:0]        s_font_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_data,
    output logic              m_read_valid
);

    localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = PAGE_COUNT * PANEL_WIDTH;
    localparam int FONT_BYTES  = GLYPH_COUNT * gtpf_pkg::GLYPH_COLS;
    localparam int FB_AW       = $clog2(FRAME_BYTES);
    localparam int FONT_AW     = $clog2(FONT_BYTES);

    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] font_mem  [FONT_BYTES];

    gtpf_pkg::state_t state_reg, state_next;

    logic [FB_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               clr_res_reg, clr_res_next;
    logic [FB_AW-1:0]   base_reg, base_next;
    logic [FONT_AW-1:0] font_base_reg, font_base_next;
    logic [2:0]         col_reg, col_next;
    logic [3:0]         cols_reg, cols_next;
    logic [7:0]         rowmask_reg, rowmask_next;
    logic [2:0]         shift_reg, shift_next;
    logic [7:0]         lo_reg, lo_next;
    logic [7:0]         hi_reg, hi_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         res_data_reg, res_data_next;
    logic               res_rv_reg, res_rv_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg, m_data_next;
    logic               m_rv_reg, m_rv_next;

    logic [7:0]         frame_q_reg;
    logic [7:0]         font_q_reg;

    logic               frame_re, frame_we;
    logic [FB_AW-1:0]   frame_raddr, frame_waddr;
    logic [7:0]         frame_wdata;
    logic               font_re, font_we;
    logic [FONT_AW-1:0] font_raddr;

    logic               accept, out_free, origin_ok, last_col;
    logic [FB_AW-1:0]   lo_addr, hi_addr;
    logic [31:0]        w_left;
    logic [7:0]         rowmask_c;
    logic [15:0]        shifted;

    assign s_ready      = (state_reg == gtpf_pkg::ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_data_reg;
    assign m_read_valid = m_rv_reg;

    assign origin_ok = !s_pos_x[8] && (32'(s_pos_x[7:0]) < 32'(PANEL_WIDTH)) &&
                       !s_pos_y[8] && (32'(s_pos_y[7:0]) < 32'(PANEL_HEIGHT));
    assign w_left    = 32'(PANEL_WIDTH) - 32'(s_pos_x[7:0]);
    assign lo_addr   = FB_AW'(32'(base_reg) + 32'(col_reg));
    assign hi_addr   = FB_AW'(32'(base_reg) + 32'(PANEL_WIDTH) + 32'(col_reg));
    assign last_col  = ((4'(col_reg) + 4'd1) == cols_reg);
    assign shifted   = 16'(font_q_reg & rowmask_reg) << shift_reg;

    always_comb begin
        for (int r = 0; r < 8; r++) begin
            rowmask_c[r] = (32'(s_pos_y[7:0]) + 32'(r)) < 32'(PANEL_HEIGHT);
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            frame_q_reg <= frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[FONT_AW'(s_address)] <= s_font_data;
        end
        if (font_re) begin
            font_q_reg <= font_mem[font_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gtpf_pkg::ST_CLR;
            clr_cnt_reg <= '0;
            clr_res_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_res_reg <= clr_res_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg      <= base_next;
        font_base_reg <= font_base_next;
        col_reg       <= col_next;
        cols_reg      <= cols_next;
        rowmask_reg   <= rowmask_next;
        shift_reg     <= shift_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        rd_ok_reg     <= rd_ok_next;
        res_data_reg  <= res_data_next;
        res_rv_reg    <= res_rv_next;
        m_data_reg    <= m_data_next;
        m_rv_reg      <= m_rv_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_res_next   = clr_res_reg;
        base_next      = base_reg;
        font_base_next = font_base_reg;
        col_next       = col_reg;
        cols_next      = cols_reg;
        rowmask_next   = rowmask_reg;
        shift_next     = shift_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rd_ok_next     = rd_ok_reg;
        res_data_next  = res_data_reg;
        res_rv_next    = res_rv_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        m_rv_next      = m_rv_reg;
        frame_re       = 1'b0;
        frame_we       = 1'b0;
        frame_raddr    = lo_addr;
        frame_waddr    = lo_addr;
        frame_wdata    = lo_reg | frame_q_reg;
        font_re        = 1'b0;
        font_we        = 1'b0;
        font_raddr     = font_base_reg + FONT_AW'(col_reg);

        unique case (state_reg)
            gtpf_pkg::ST_CLR: begin
                frame_we    = 1'b1;
                frame_waddr = clr_cnt_reg;
                frame_wdata = 8'd0;
                clr_cnt_next = clr_cnt_reg + FB_AW'(1);
                if (clr_cnt_reg == FB_AW'(FRAME_BYTES - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = clr_res_reg ? gtpf_pkg::ST_FIN : gtpf_pkg::ST_IDLE;
                end
            end
            gtpf_pkg::ST_IDLE: begin
                if (accept) begin
                    res_data_next = 8'd0;
                    res_rv_next   = 1'b0;
                    unique case (s_op)
                        gtpf_pkg::OP_CLEAR: begin
                            clr_cnt_next = '0;
                            clr_res_next = 1'b1;
                            state_next   = gtpf_pkg::ST_CLR;
                        end
                        gtpf_pkg::OP_DRAW: begin
                            base_next = FB_AW'(32'(s_pos_y[7:3]) * 32'(PANEL_WIDTH) +
                                               32'(s_pos_x[7:0]));
                            font_base_next = FONT_AW'({gtpf_pkg::glyph_of(s_char_code),
                                                       3'b000});
                            col_next     = 3'd0;
                            cols_next    = (w_left >= 32'd8) ? 4'd8 : 4'(w_left);
                            rowmask_next = rowmask_c;
                            shift_next   = s_pos_y[2:0];
                            state_next   = origin_ok ? gtpf_pkg::ST_FONT
                                                     : gtpf_pkg::ST_FIN;
                        end
                        gtpf_pkg::OP_LOAD: begin
                            font_we    = (32'(s_address) < 32'(FONT_BYTES));
                            state_next = gtpf_pkg::ST_FIN;
                        end
                        gtpf_pkg::OP_READ: begin
                            frame_re    = 1'b1;
                            frame_raddr = FB_AW'(s_address);
                            rd_ok_next  = (32'(s_address) < 32'(FRAME_BYTES));
                            state_next  = gtpf_pkg::ST_RD;
                        end
                        default: state_next = gtpf_pkg::ST_FIN;
                    endcase
                end
            end
            gtpf_pkg::ST_RD: begin
                res_data_next = rd_ok_reg ? frame_q_reg : 8'd0;
                res_rv_next   = 1'b1;
                state_next    = gtpf_pkg::ST_FIN;
            end
            gtpf_pkg::ST_FONT: begin
                font_re    = 1'b1;
                state_next = gtpf_pkg::ST_LORD;
            end
            gtpf_pkg::ST_LORD: begin
                lo_next     = shifted[7:0];
                hi_next     = shifted[15:8];
                frame_re    = 1'b1;
                frame_raddr = lo_addr;
                state_next  = gtpf_pkg::ST_LO;
            end
            gtpf_pkg::ST_LO: begin
                frame_we    = 1'b1;
                frame_waddr = lo_addr;
                frame_wdata = lo_reg | frame_q_reg;
                frame_re    = 1'b1;
                frame_raddr = hi_addr;
                if (hi_reg != 8'd0) begin
                    state_next = gtpf_pkg::ST_HI;
                end else if (last_col) begin
                    state_next = gtpf_pkg::ST_FIN;
                end else begin
                    col_next   = col_reg + 3'd1;
                    font_re    = 1'b1;
                    font_raddr = font_base_reg + FONT_AW'(col_reg + 3'd1);
                    state_next = gtpf_pkg::ST_LORD;
                end
            end
            gtpf_pkg::ST_HI: begin
                frame_we    = 1'b1;
                frame_waddr = hi_addr;
                frame_wdata = hi_reg | frame_q_reg;
                if (last_col) begin
                    state_next = gtpf_pkg::ST_FIN;
                end else begin
                    col_next   = col_reg + 3'd1;
                    font_re    = 1'b1;
                    font_raddr = font_base_reg + FONT_AW'(col_reg + 3'd1);
                    state_next = gtpf_pkg::ST_LORD;
                end
            end
            gtpf_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_rv_next    = res_rv_reg;
                    clr_res_next = 1'b0;
                    state_next   = gtpf_pkg::ST_IDLE;
                end
            end
            default: state_next = gtpf_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/gtpf_checker.sv -----
// Port-level checker for the glyph-to-page framebuffer, bound to the top level.
// Watches the two channels only. Depends on glyph_to_page_framebuffer.
module gtpf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [1:0]        s_op,
    input logic signed [8:0] s_pos_x,
    input logic signed [8:0] s_pos_y,
    input logic [7:0]        s_char_code,
    input logic [9:0]        s_address,
    input logic [7:0]        s_font_data,
    input logic              m_valid,
    input logic              m_ready,
    input logic [7:0]        m_read_data,
    input logic              m_read_valid
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid &&
            $stable({s_op, s_pos_x, s_pos_y, s_char_code, s_address, s_font_data}))
        else $error("command word changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_read_valid))
        else $error("result word changed while stalled");

    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_read_valid |-> m_read_data == 8'd0)
        else $error("non-read result carries data");

    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted before the first finished");

endmodule

bind glyph_to_page_framebuffer gtpf_checker u_gtpf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .s_pos_x      (s_pos_x),
    .s_pos_y      (s_pos_y),
    .s_char_code  (s_char_code),
    .s_address    (s_address),
    .s_font_data  (s_font_data),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_read_valid (m_read_valid)
);
